/* rtl/core/second_chance_page_replacement_top_macros.svh */
// assertion macros for the second-chance page replacement block
// used by the top level only, no other dependencies
`ifndef SECOND_CHANCE_PAGE_REPLACEMENT_TOP_MACROS_SVH
`define SECOND_CHANCE_PAGE_REPLACEMENT_TOP_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SCPR_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("scpr check failed");

// next-cycle implication, disabled while reset is asserted
`define SCPR_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("scpr check failed");

`endif

/* rtl/core/scpr_pkg.sv */
// shared constants, state encoding and command/status types
// for the second-chance page replacement block; no dependencies
package scpr_pkg;

	localparam int unsigned MAX_FRAMES = 16;
	localparam int unsigned PAGE_BITS  = 16;
	localparam int unsigned SLOT_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int unsigned CNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int unsigned CFG_W      = 5;
	localparam int unsigned FAULT_W    = 32;
	localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(16);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_SWEEP,
		ST_EMIT
	} scpr_state_t;

	// controller to datapath
	typedef struct packed {
		logic load_item;
		logic set_refs;
		logic wrap_hand;
		logic skip_slot;
		logic replace;
		logic load_out;
		logic clear_table;
	} scpr_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;
		logic hand_ref;
		logic out_free;
		logic last;
	} scpr_sts_t;

endpackage

/* rtl/core/scpr_ifs.sv */
// valid/ready channel interfaces for page references and results
// depends on scpr_pkg
interface scpr_ref_if import scpr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [PAGE_BITS-1:0] page_number;
	logic                 last_reference;

	modport source (output valid, output page_number, output last_reference, input ready);
	modport sink (input valid, input page_number, input last_reference, output ready);
endinterface

interface scpr_res_if import scpr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic                 hit;
	logic [SLOT_W-1:0]    frame_slot;
	logic                 evicted_valid;
	logic [PAGE_BITS-1:0] evicted_page;
	logic [FAULT_W-1:0]   fault_count;
	logic                 string_done;

	modport source (output valid, output hit, output frame_slot, output evicted_valid,
		output evicted_page, output fault_count, output string_done, input ready);
	modport sink (input valid, input hit, input frame_slot, input evicted_valid,
		input evicted_page, input fault_count, input string_done, output ready);
endinterface

/* rtl/core/scpr_datapath.sv */
// frame table, clock hand, fault counter and result/output registers
// depends on scpr_pkg
module scpr_datapath import scpr_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_W-1:0]     cfg_wdata,
	input  logic [PAGE_BITS-1:0] page_number,
	input  logic                 last_reference,
	input  scpr_cmd_t            cmd,
	output scpr_sts_t            sts,
	input  logic                 out_ready,
	output logic                 out_valid,
	output logic                 hit,
	output logic [SLOT_W-1:0]    frame_slot,
	output logic                 evicted_valid,
	output logic [PAGE_BITS-1:0] evicted_page,
	output logic [FAULT_W-1:0]   fault_count,
	output logic                 string_done
);

	logic [CFG_W-1:0]      cfg_q;
	logic [MAX_FRAMES-1:0] valid_q;
	logic [MAX_FRAMES-1:0] ref_q;
	logic [SLOT_W-1:0]     hand_q;
	logic [FAULT_W-1:0]    faults_q;
	logic                  out_valid_q;

	logic [PAGE_BITS-1:0]  pages_q [MAX_FRAMES];
	logic [PAGE_BITS-1:0]  item_page_q;
	logic                  item_last_q;
	logic                  res_hit_q;
	logic [SLOT_W-1:0]     res_slot_q;
	logic                  res_ev_valid_q;
	logic [PAGE_BITS-1:0]  res_ev_page_q;
	logic                  out_hit_q;
	logic [SLOT_W-1:0]     out_slot_q;
	logic                  out_ev_valid_q;
	logic [PAGE_BITS-1:0]  out_ev_page_q;
	logic [FAULT_W-1:0]    out_faults_q;
	logic                  out_done_q;

	logic [CNT_W-1:0]      n_eff;
	logic [SLOT_W:0]       n_ext;
	logic [SLOT_W:0]       hand_inc;
	logic [SLOT_W-1:0]     hand_next;
	logic [MAX_FRAMES-1:0] match;
	logic [SLOT_W-1:0]     hit_slot;

	// zero acts as one frame, oversize as all frames
	always_comb begin
		if (cfg_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (32'(cfg_q) > MAX_FRAMES) begin
			n_eff = CNT_W'(MAX_FRAMES);
		end else begin
			n_eff = CNT_W'(cfg_q);
		end
	end

	assign n_ext     = (SLOT_W + 1)'(n_eff);
	assign hand_inc  = {1'b0, hand_q} + 1'b1;
	assign hand_next = (hand_inc >= n_ext) ? '0 : hand_inc[SLOT_W-1:0];

	// parallel compare over active frames, lowest match wins the report
	always_comb begin
		for (int i = 0; i < MAX_FRAMES; i++) begin
			match[i] = valid_q[i] && (pages_q[i] == item_page_q) && ((CNT_W + 1)'(i) < (CNT_W + 1)'(n_eff));
		end
		hit_slot = '0;
		for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
			if (match[i]) begin
				hit_slot = SLOT_W'(i);
			end
		end
	end

	assign sts.hit      = |match;
	assign sts.hand_ref = ref_q[hand_q];
	assign sts.out_free = !out_valid_q || out_ready;
	assign sts.last     = item_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q       <= CFG_RESET;
			valid_q     <= '0;
			ref_q       <= '0;
			hand_q      <= '0;
			faults_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cfg_q <= cfg_wdata;
			end
			if (cmd.clear_table) begin
				valid_q  <= '0;
				ref_q    <= '0;
				hand_q   <= '0;
				faults_q <= '0;
			end else if (cmd.set_refs) begin
				ref_q <= ref_q | match;
			end else if (cmd.wrap_hand) begin
				if ({1'b0, hand_q} >= n_ext) begin
					hand_q <= '0;
				end
			end else if (cmd.skip_slot) begin
				ref_q[hand_q] <= 1'b0;
				hand_q        <= hand_next;
			end else if (cmd.replace) begin
				valid_q[hand_q] <= 1'b1;
				ref_q[hand_q]   <= 1'b0;
				hand_q          <= hand_next;
				if (faults_q != '1) begin
					faults_q <= faults_q + 1'b1;
				end
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			item_page_q <= page_number;
			item_last_q <= last_reference;
		end
		if (cmd.set_refs) begin
			res_hit_q      <= 1'b1;
			res_slot_q     <= hit_slot;
			res_ev_valid_q <= 1'b0;
			res_ev_page_q  <= '0;
		end
		if (cmd.replace) begin
			res_hit_q       <= 1'b0;
			res_slot_q      <= hand_q;
			res_ev_valid_q  <= valid_q[hand_q];
			res_ev_page_q   <= valid_q[hand_q] ? pages_q[hand_q] : '0;
			pages_q[hand_q] <= item_page_q;
		end
		if (cmd.load_out) begin
			out_hit_q      <= res_hit_q;
			out_slot_q     <= res_slot_q;
			out_ev_valid_q <= res_ev_valid_q;
			out_ev_page_q  <= res_ev_page_q;
			out_faults_q   <= faults_q;
			out_done_q     <= item_last_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign hit           = out_hit_q;
	assign frame_slot    = out_slot_q;
	assign evicted_valid = out_ev_valid_q;
	assign evicted_page  = out_ev_page_q;
	assign fault_count   = out_faults_q;
	assign string_done   = out_done_q;

endmodule

/* rtl/core/scpr_ctrl.sv */
// controller state machine: lookup, one-frame-per-cycle sweep, result hand-off
// depends on scpr_pkg
module scpr_ctrl import scpr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  scpr_sts_t sts,
	output scpr_cmd_t cmd
);

	scpr_state_t state_q;
	scpr_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		cmd      = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_item = 1'b1;
					state_d       = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (sts.hit) begin
					cmd.set_refs = 1'b1;
					state_d      = ST_EMIT;
				end else begin
					cmd.wrap_hand = 1'b1;
					state_d       = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				if (sts.hand_ref) begin
					cmd.skip_slot = 1'b1;
				end else begin
					cmd.replace = 1'b1;
					state_d     = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (sts.out_free) begin
					cmd.load_out    = 1'b1;
					cmd.clear_table = sts.last;
					state_d         = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* rtl/core/second_chance_page_replacement_top.sv */
// top level of the second-chance (clock) page replacement block
// depends on scpr_pkg, scpr_ifs, scpr_ctrl, scpr_datapath and the macros header
//
// usage
// - ref_ch carries one page reference per item (page_number, last_reference)
// - res_ch returns exactly one result per item, in order
// - cfg_we/cfg_wdata write frames_in_use; write it only while the block is idle
// - a hit goes from lookup straight to emit; a fault goes from lookup into the sweep,
//   which clears each set reference bit the hand passes (0 to frames in use)
//   and then replaces the first frame whose reference bit is clear
// - the sweep moves the hand one frame per cycle; that loop sets the fault time
// - one item is in work at a time; ref_ch.ready is high only between items
// - the result sits in an output register, so the next item is taken while
//   an earlier result still waits on res_ch
// - if res_ch stalls, a finished item waits in its emit step and no new item
//   is taken until the output register frees up
// - after a result with string_done the table, hand and fault count clear;
//   frames_in_use is kept
// - reset empties the table, zeroes hand and fault count, sets frames_in_use to 16
`include "second_chance_page_replacement_top_macros.svh"

module second_chance_page_replacement_top import scpr_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	scpr_ref_if.sink         ref_ch,
	scpr_res_if.source       res_ch
);

	// command and status between controller and datapath
	scpr_cmd_t cmd;
	scpr_sts_t sts;

	// sequencer: idle, lookup, sweep, emit
	scpr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (ref_ch.valid),
		.in_ready (ref_ch.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// frame table, hand, fault counter, output register
	scpr_datapath u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.page_number    (ref_ch.page_number),
		.last_reference (ref_ch.last_reference),
		.cmd            (cmd),
		.sts            (sts),
		.out_ready      (res_ch.ready),
		.out_valid      (res_ch.valid),
		.hit            (res_ch.hit),
		.frame_slot     (res_ch.frame_slot),
		.evicted_valid  (res_ch.evicted_valid),
		.evicted_page   (res_ch.evicted_page),
		.fault_count    (res_ch.fault_count),
		.string_done    (res_ch.string_done)
	);

	// a hit never evicts anything
	`SCPR_ASSERT_SAME(a_hit_no_evict, clk, arst_n, res_ch.valid && res_ch.hit, !res_ch.evicted_valid)
	// a fault result always carries a nonzero count
	`SCPR_ASSERT_SAME(a_fault_counted, clk, arst_n, res_ch.valid && !res_ch.hit, res_ch.fault_count != '0)
	// after taking an item the block is busy for at least the lookup cycle
	`SCPR_ASSERT_NEXT(a_one_item, clk, arst_n, ref_ch.valid && ref_ch.ready, !ref_ch.ready)

endmodule
